// ----- rtl/core/u8d_pkg.sv -----
// u8d_pkg: shared types, constants and helpers of the utf-8 validating decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package u8d_pkg;

  // code point constants
  localparam logic [20:0] REPL_CP    = 21'h00FFFD;
  localparam logic [20:0] MAX_CP     = 21'h10FFFF;
  localparam logic [20:0] SUR_LO     = 21'h00D800;
  localparam logic [20:0] SUR_HI     = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [20:0] HI_SUR_BASE = 21'h00D800;
  localparam logic [20:0] LO_SUR_BASE = 21'h00DC00;
  localparam logic [20:0] MIN_TWO    = 21'h000080;
  localparam logic [20:0] MIN_THREE  = 21'h000800;
  localparam logic [20:0] MIN_FOUR   = 21'h010000;

  // claimed sequence lengths
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // descriptor queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // work for one input byte: nrep replacements, then an optional code point
  typedef struct packed {
    logic [2:0]  nrep;
    logic        main_en;
    logic        split;
    logic [20:0] value;
    logic        eot;
  } desc_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    begin
      if (b[7] == 1'b0) begin
        len = LEN_ONE;
      end else if (b[7:5] == 3'b110) begin
        len = LEN_TWO;
      end else if (b[7:4] == 4'b1110) begin
        len = LEN_THREE;
      end else if (b[7:3] == 5'b11110) begin
        len = LEN_FOUR;
      end else begin
        len = LEN_NONE;
      end
      return len;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/u8d_front.sv -----
// u8d_front: sequence state and classification of each accepted byte
// depends on u8d_pkg; produces one descriptor per byte that causes output
`default_nettype none

module u8d_front import u8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       mode_i,
  output desc_t      desc_o,
  output logic       desc_en_o
);

  logic [20:0] pv_q, pv_d;
  logic [2:0]  cl_q, cl_d;
  logic [1:0]  bh_q, bh_d;

  logic        is_cont;
  logic [20:0] nv;
  logic [2:0]  held_inc;
  logic [2:0]  pre;
  logic [2:0]  len;
  logic        bad;
  logic [2:0]  nrep;
  logic        main_en;
  logic [20:0] value;

  assign is_cont  = (text_byte_i[7:6] == 2'b10);
  assign nv       = {pv_q[14:0], text_byte_i[5:0]};
  assign held_inc = {1'b0, bh_q} + 3'd1;
  assign len      = lead_len(text_byte_i);

  // overlong, surrogate or out of range
  assign bad = ((cl_q == LEN_TWO)   && (nv < MIN_TWO))   ||
               ((cl_q == LEN_THREE) && (nv < MIN_THREE)) ||
               ((cl_q == LEN_FOUR)  && (nv < MIN_FOUR))  ||
               ((nv >= SUR_LO) && (nv <= SUR_HI))        ||
               (nv > MAX_CP);

  always_comb begin
    pv_d    = pv_q;
    cl_d    = cl_q;
    bh_d    = bh_q;
    nrep    = 3'd0;
    main_en = 1'b0;
    value   = nv;
    pre     = 3'd0;
    if ((cl_q != LEN_NONE) && is_cont) begin
      if (held_inc >= cl_q) begin
        pv_d = '0;
        cl_d = LEN_NONE;
        bh_d = 2'd0;
        if (bad) begin
          nrep = 3'd1;
        end else begin
          main_en = 1'b1;
        end
      end else begin
        pv_d = nv;
        bh_d = held_inc[1:0];
        if (end_of_text_i) begin
          nrep = held_inc;
          pv_d = '0;
          cl_d = LEN_NONE;
          bh_d = 2'd0;
        end
      end
    end else begin
      // broken sequence flushes its held bytes, then the byte starts anew
      if (cl_q != LEN_NONE) begin
        pre = {1'b0, bh_q};
      end
      pv_d = '0;
      cl_d = LEN_NONE;
      bh_d = 2'd0;
      case (len)
        LEN_NONE: begin
          nrep = pre + 3'd1;
        end
        LEN_ONE: begin
          nrep    = pre;
          main_en = 1'b1;
          value   = {13'd0, text_byte_i};
        end
        default: begin
          case (len)
            LEN_TWO:   pv_d = {16'd0, text_byte_i[4:0]};
            LEN_THREE: pv_d = {17'd0, text_byte_i[3:0]};
            default:   pv_d = {18'd0, text_byte_i[2:0]};
          endcase
          cl_d = len;
          bh_d = 2'd1;
          nrep = pre;
          if (end_of_text_i) begin
            nrep = pre + 3'd1;
            pv_d = '0;
            cl_d = LEN_NONE;
            bh_d = 2'd0;
          end
        end
      endcase
    end
  end

  assign desc_o.nrep    = nrep;
  assign desc_o.main_en = main_en;
  assign desc_o.split   = main_en && mode_i && (value >= SUPP_BASE);
  assign desc_o.value   = value;
  assign desc_o.eot     = end_of_text_i;
  assign desc_en_o      = take_i && (main_en || (nrep != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      cl_q <= LEN_NONE;
      bh_q <= 2'd0;
    end else if (take_i) begin
      pv_q <= pv_d;
      cl_q <= cl_d;
      bh_q <= bh_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8d_queue.sv -----
// u8d_queue: short descriptor queue between front and back
// depends on u8d_pkg for desc_t and the queue depth
`default_nettype none

module u8d_queue import u8d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  valid_o
);

  desc_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d;
  logic [QPtrW-1:0]  rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8d_back.sv -----
// u8d_back: expands one descriptor into result units, one per cycle while the consumer pops
// depends on u8d_pkg; holds the output register read by the consumer
`default_nettype none

module u8d_back import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  desc_t       head_i,
  input  logic        head_valid_i,
  output logic        head_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [20:0] unit_value_o,
  output logic        is_replacement_o,
  output logic        run_end_o,
  output logic        text_done_o
);

  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [20:0] unit_q;
  logic        rep_q, end_q, done_q;

  logic [2:0]  total;
  logic [20:0] offs;
  logic [20:0] hi_unit, lo_unit;
  logic        cur_rep, last, load;
  logic [20:0] cur_unit;

  assign total = head_i.nrep +
                 (head_i.main_en ? (head_i.split ? 3'd2 : 3'd1) : 3'd0);
  assign offs    = head_i.value - SUPP_BASE;
  assign hi_unit = HI_SUR_BASE + {11'd0, offs[19:10]};
  assign lo_unit = LO_SUR_BASE + {11'd0, offs[9:0]};
  assign cur_rep = (idx_q < head_i.nrep);
  assign last    = (idx_q == (total - 3'd1));

  always_comb begin
    if (cur_rep) begin
      cur_unit = REPL_CP;
    end else if (head_i.split) begin
      cur_unit = (idx_q == head_i.nrep) ? hi_unit : lo_unit;
    end else begin
      cur_unit = head_i.value;
    end
  end

  assign load       = head_valid_i && (!out_valid_q || pop_i);
  assign head_pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? 3'd0 : idx_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q <= cur_unit;
      rep_q  <= cur_rep;
      end_q  <= last;
      done_q <= last && head_i.eot;
    end
  end

  assign empty_o          = !out_valid_q;
  assign unit_value_o     = unit_q;
  assign is_replacement_o = rep_q;
  assign run_end_o        = end_q;
  assign text_done_o      = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/utf8_validating_decoder.sv -----
// utf8_validating_decoder: top level, front classifier, descriptor queue, back expander
// depends on u8d_pkg, u8d_front, u8d_queue and u8d_back
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------------
// bytes     | in        | push / full                | text_byte_i, end_of_text_i
// units     | out       | pop / empty                | unit_value_o, is_replacement_o,
//           |           |                            | run_end_o, text_done_o
// config    | in        | cfg_we_i                   | cfg_wdata_i (output_mode)
//
// one byte can be taken every cycle while the descriptor queue has room
// the back end hands out the result units of a byte one at a time;
// at most four units per byte
// full depends only on the queue fill, never combinationally on pop
// reset clears the pending sequence, the queue, the output register and output_mode
`default_nettype none

module utf8_validating_decoder import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input transactions
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [20:0] unit_value_o,
  output logic        is_replacement_o,
  output logic        run_end_o,
  output logic        text_done_o,
  // output_mode register write
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic  mode_q;
  logic  take;
  desc_t front_desc;
  logic  front_en;
  desc_t head;
  logic  head_valid;
  logic  head_pop;

  // output_mode: 0 code points, 1 utf-16 code units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // a byte transaction completes when the queue has room
  assign take = push && !full;

  // front: tracks the pending sequence and turns each byte into a descriptor;
  // bytes that only extend a sequence produce no descriptor
  u8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .mode_i        (mode_q),
    .desc_o        (front_desc),
    .desc_en_o     (front_en)
  );

  // decouples the classifier from the unit expander
  u8d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_en),
    .desc_i  (front_desc),
    .full_o  (full),
    .pop_i   (head_pop),
    .head_o  (head),
    .valid_o (head_valid)
  );

  // back: replacements first, then the code point or its surrogate pair
  u8d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_valid_i     (head_valid),
    .head_pop_o       (head_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .unit_value_o     (unit_value_o),
    .is_replacement_o (is_replacement_o),
    .run_end_o        (run_end_o),
    .text_done_o      (text_done_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/u8d_checker.sv -----
// u8d_checker: port-level checks of the utf-8 decoder over time
// depends on u8d_pkg; bound to utf8_validating_decoder at the end of this file
`default_nettype none

module u8d_checker import u8d_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [20:0] unit_value_o,
  input logic        is_replacement_o,
  input logic        run_end_o,
  input logic        text_done_o
);

  // end of text always closes the run of its byte
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && text_done_o |-> run_end_o)
    else $error("text_done without run_end");

  // replacements carry the replacement character
  a_repl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && is_replacement_o |-> unit_value_o == REPL_CP)
    else $error("replacement with wrong value");

  // no unit beyond the code space
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> unit_value_o <= MAX_CP)
    else $error("unit above code space");

  // a waiting result stays put until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(unit_value_o) && $stable(is_replacement_o))
    else $error("waiting result changed");

endmodule

bind utf8_validating_decoder u8d_checker u_u8d_checker (.*);

`default_nettype wire
